@@ hw/rtl/piecewise_bezier_path_eval_macros.svh @@
// Assertion macros for the piecewise Bezier path evaluator.
// Included by the top level; needs no package.
`ifndef PIECEWISE_BEZIER_PATH_EVAL_MACROS_SVH
`define PIECEWISE_BEZIER_PATH_EVAL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define PBPE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define PBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/pbpe_pkg.sv @@
// Shared types, constants and helper functions of the Bezier path evaluator.
// No dependencies; used by every module of the block.
package pbpe_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned T_W     = 17;
   localparam int unsigned CNT_W   = 7;
   localparam int unsigned ENTRY_W = 6;
   localparam int unsigned SEG_W   = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 7;
   localparam int unsigned QW      = 34;    // de Casteljau working width
   localparam int unsigned QUEUE_DEPTH = 2;

   // Opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_ORDER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_HANDLES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT    = 2'd2;

   // Handle compression constants
   localparam logic [31:0] SAT_MAG_LIMIT = 32'd21804525; // |v| giving exponent >= 16
   localparam logic [25:0] RECIP15       = 26'd35791395; // ceil(2^29 / 15)
   localparam logic [27:0] LN2_Q24       = 28'd11629080;
   localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
   localparam logic [3:0]  TAYLOR_TERMS  = 4'd12;
   localparam logic signed [33:0] ONE_Q16 = 34'sd65536;
   localparam logic [16:0] FRAC_ONE      = 17'h10000;
   localparam logic [2:0]  LERPS_CUBIC   = 3'd6;
   localparam logic [2:0]  LERPS_QUAD    = 3'd3;

   // Queue entry between front and back
   typedef struct packed {
      logic                      opcode;
      logic [ENTRY_W-1:0]        entry_index;
      logic signed [COORD_W-1:0] anchor_x;
      logic signed [COORD_W-1:0] anchor_y;
      logic signed [COORD_W-1:0] out_handle_x;
      logic signed [COORD_W-1:0] out_handle_y;
      logic signed [COORD_W-1:0] in_handle_x;
      logic signed [COORD_W-1:0] in_handle_y;
      logic [SEG_W-1:0]          seg;
      logic [T_W-1:0]            frac;
      logic                      invalid;
   } job_type;

   // One row of the point table
   typedef struct packed {
      logic signed [COORD_W-1:0] anchor_x;
      logic signed [COORD_W-1:0] anchor_y;
      logic signed [COORD_W-1:0] out_handle_x;
      logic signed [COORD_W-1:0] out_handle_y;
      logic signed [COORD_W-1:0] in_handle_x;
      logic signed [COORD_W-1:0] in_handle_y;
   } row_type;

   // Queue status toward the top level
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_READ0, S_READ1, S_CDIV, S_CREM, S_CLN, S_TMUL, S_TDIV,
      S_TFIX, S_CFIN, S_BUILD, S_LMUL, S_LADD, S_DONE
   } back_state_type;

   // floor(128 * r / 15) for r < 15
   function automatic logic [6:0] frac128_div15(input logic [3:0] r);
      logic [6:0] v;
      case (r)
         4'd0:    v = 7'd0;
         4'd1:    v = 7'd8;
         4'd2:    v = 7'd17;
         4'd3:    v = 7'd25;
         4'd4:    v = 7'd34;
         4'd5:    v = 7'd42;
         4'd6:    v = 7'd51;
         4'd7:    v = 7'd59;
         4'd8:    v = 7'd68;
         4'd9:    v = 7'd76;
         4'd10:   v = 7'd85;
         4'd11:   v = 7'd93;
         4'd12:   v = 7'd102;
         4'd13:   v = 7'd110;
         4'd14:   v = 7'd119;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

   // floor((2^32 - 1) / k); the estimate is low by at most one
   function automatic logic [31:0] recip_k(input logic [3:0] k);
      logic [31:0] v;
      case (k)
         4'd1:    v = 32'd4294967295;
         4'd2:    v = 32'd2147483647;
         4'd3:    v = 32'd1431655765;
         4'd4:    v = 32'd1073741823;
         4'd5:    v = 32'd858993459;
         4'd6:    v = 32'd715827882;
         4'd7:    v = 32'd613566756;
         4'd8:    v = 32'd536870911;
         4'd9:    v = 32'd477218588;
         4'd10:   v = 32'd429496729;
         4'd11:   v = 32'd390451572;
         4'd12:   v = 32'd357913941;
         default: v = 32'd4294967295;
      endcase
      return v;
   endfunction

   // Left index of the pair reduced at each de Casteljau step
   function automatic logic [1:0] lerp_index(input logic cubic, input logic [2:0] step);
      logic [1:0] v;
      case ({cubic, step})
         4'b1_000: v = 2'd0;
         4'b1_001: v = 2'd1;
         4'b1_010: v = 2'd2;
         4'b1_011: v = 2'd0;
         4'b1_100: v = 2'd1;
         4'b1_101: v = 2'd0;
         4'b0_000: v = 2'd0;
         4'b0_001: v = 2'd1;
         4'b0_010: v = 2'd0;
         default:  v = 2'd0;
      endcase
      return v;
   endfunction

   // Saturate the working width to a 32-bit coordinate
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [QW-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/pbpe_front.sv @@
// Front end: classifies an incoming transaction and picks segment and fraction.
// Depends on pbpe_pkg.
module pbpe_front #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic                               opcode,
   input  logic [pbpe_pkg::ENTRY_W-1:0]       entry_index,
   input  logic signed [pbpe_pkg::COORD_W-1:0] anchor_x,
   input  logic signed [pbpe_pkg::COORD_W-1:0] anchor_y,
   input  logic signed [pbpe_pkg::COORD_W-1:0] out_handle_x,
   input  logic signed [pbpe_pkg::COORD_W-1:0] out_handle_y,
   input  logic signed [pbpe_pkg::COORD_W-1:0] in_handle_x,
   input  logic signed [pbpe_pkg::COORD_W-1:0] in_handle_y,
   input  logic [pbpe_pkg::T_W-1:0]           eval_position,
   input  logic [pbpe_pkg::CNT_W-1:0]         point_count,
   output pbpe_pkg::job_type                  job
);

   localparam int unsigned CAP = (MAX_POINTS < 127) ? MAX_POINTS : 127;

   logic [pbpe_pkg::CNT_W-1:0] cnt;
   logic [pbpe_pkg::CNT_W-1:0] segs;
   logic [22:0]                pos_prod;

   // Usable anchor count and segment count
   assign cnt  = (point_count > pbpe_pkg::CNT_W'(CAP)) ? pbpe_pkg::CNT_W'(CAP) : point_count;
   assign segs = cnt - 7'd1;

   // t * segments; the integer part is the segment, the rest the fraction
   assign pos_prod = eval_position[15:0] * segs;

   always_comb begin
      job.opcode       = opcode;
      job.entry_index  = entry_index;
      job.anchor_x     = anchor_x;
      job.anchor_y     = anchor_y;
      job.out_handle_x = out_handle_x;
      job.out_handle_y = out_handle_y;
      job.in_handle_x  = in_handle_x;
      job.in_handle_y  = in_handle_y;
      job.invalid      = (cnt < 7'd2);
      // t at or above one lands on the end of the last segment
      if (eval_position[16]) begin
         job.seg  = segs - 7'd1;
         job.frac = pbpe_pkg::FRAC_ONE;
      end else begin
         job.seg  = pos_prod[22:16];
         job.frac = {1'b0, pos_prod[15:0]};
      end
   end

endmodule

@@ hw/rtl/pbpe_queue.sv @@
// Two-entry queue between front and back end.
// Depends on pbpe_pkg.
module pbpe_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pbpe_pkg::job_type          push_data,
   input  logic                       pop,
   output pbpe_pkg::job_type          pop_data,
   output pbpe_pkg::queue_status_type status
);

   pbpe_pkg::job_type slot_ff [pbpe_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'(pbpe_pkg::QUEUE_DEPTH));

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/pbpe_back.sv @@
// Back end: point table, handle compression and de Casteljau sequencer.
// Depends on pbpe_pkg.
module pbpe_back #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pbpe_pkg::job_type                   job,
   input  logic                                job_valid,
   output logic                                pop,
   input  logic                                curve_order,
   input  logic                                direct_handles,
   output logic                                rsp_strobe,
   output logic signed [pbpe_pkg::COORD_W-1:0] pos_x,
   output logic signed [pbpe_pkg::COORD_W-1:0] pos_y,
   output logic                                path_invalid
);

   localparam int unsigned IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

   // Point table
   pbpe_pkg::row_type mem [MAX_POINTS];
   pbpe_pkg::row_type row_ff;
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_waddr, mem_raddr;
   pbpe_pkg::row_type mem_wdata;

   pbpe_pkg::back_state_type state_ff, state_in;
   pbpe_pkg::job_type job_ff, job_in;

   logic signed [31:0] h_ff [4];
   logic signed [31:0] h_in [4];
   logic signed [31:0] ax0_ff, ax0_in, ay0_ff, ay0_in, ax1_ff, ax1_in, ay1_ff, ay1_in;

   // Compression datapath
   logic [1:0]  hsel_ff, hsel_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in, sat_ff, sat_in;
   logic [50:0] p15_ff, p15_in;
   logic [27:0] x_ff, x_in;
   logic [3:0]  n_ff, n_in;
   logic [29:0] r30_ff, r30_in;
   logic [30:0] term_ff, term_in;
   logic [31:0] sum_ff, sum_in;
   logic [3:0]  k_ff, k_in;
   logic [60:0] tprod_ff, tprod_in;
   logic [30:0] a_ff, a_in;
   logic [62:0] qe_ff, qe_in;

   // de Casteljau datapath
   logic signed [pbpe_pkg::QW-1:0] qx_ff [4];
   logic signed [pbpe_pkg::QW-1:0] qx_in [4];
   logic signed [pbpe_pkg::QW-1:0] qy_ff [4];
   logic signed [pbpe_pkg::QW-1:0] qy_in [4];
   logic [2:0]         step_ff, step_in;
   logic signed [52:0] lpx_ff, lpx_in, lpy_ff, lpy_in;

   // Result register
   logic                                rsp_strobe_ff, rsp_strobe_in;
   logic signed [pbpe_pkg::COORD_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic                                invalid_ff, invalid_in;

   assign rsp_strobe   = rsp_strobe_ff;
   assign pos_x        = pos_x_ff;
   assign pos_y        = pos_y_ff;
   assign path_invalid = invalid_ff;

   // Sequencer and datapath next values
   always_comb begin
      logic [21:0]        q15;
      logic [25:0]        q15x15;
      logic [3:0]         r15;
      logic [28:0]        x_full;
      logic [27:0]        ln_rem;
      logic [3:0]         ln_n;
      logic [30:0]        q_est;
      logic [35:0]        qk;
      logic [35:0]        a_rem;
      logic [46:0]        scaled;
      logic signed [33:0] res;
      logic [30:0]        res_mag;
      logic signed [31:0] h_val;
      logic [1:0]         li, li1;
      logic signed [pbpe_pkg::QW:0] dx, dy;
      logic [6:0]         seg1;

      state_in = state_ff;
      job_in   = job_ff;
      h_in     = h_ff;
      ax0_in = ax0_ff; ay0_in = ay0_ff; ax1_in = ax1_ff; ay1_in = ay1_ff;
      hsel_in = hsel_ff; mag_in = mag_ff; neg_in = neg_ff; sat_in = sat_ff;
      p15_in = p15_ff; x_in = x_ff; n_in = n_ff; r30_in = r30_ff;
      term_in = term_ff; sum_in = sum_ff; k_in = k_ff;
      tprod_in = tprod_ff; a_in = a_ff; qe_in = qe_ff;
      qx_in = qx_ff; qy_in = qy_ff; step_in = step_ff;
      lpx_in = lpx_ff; lpy_in = lpy_ff;
      rsp_strobe_in = 1'b0;
      pos_x_in = pos_x_ff; pos_y_in = pos_y_ff; invalid_in = invalid_ff;
      pop = 1'b0;
      mem_we = 1'b0; mem_re = 1'b0;
      mem_waddr = IDX_W'(job.entry_index);
      mem_raddr = IDX_W'(job.seg);
      mem_wdata.anchor_x     = job.anchor_x;
      mem_wdata.anchor_y     = job.anchor_y;
      mem_wdata.out_handle_x = job.out_handle_x;
      mem_wdata.out_handle_y = job.out_handle_y;
      mem_wdata.in_handle_x  = job.in_handle_x;
      mem_wdata.in_handle_y  = job.in_handle_y;

      q15    = p15_ff[50:29];
      q15x15 = {q15, 4'd0} - {4'd0, q15};
      r15    = 4'(mag_ff[25:0] - q15x15);
      x_full = {q15, 7'd0} + {22'd0, pbpe_pkg::frac128_div15(r15)};
      ln_rem = x_ff;
      ln_n   = 4'd0;
      for (int b = 3; b >= 0; b--) begin
         if (ln_rem >= (pbpe_pkg::LN2_Q24 << b)) begin
            ln_rem  = ln_rem - (pbpe_pkg::LN2_Q24 << b);
            ln_n[b] = 1'b1;
         end
      end
      q_est   = qe_ff[62:32];
      qk      = q_est * k_ff;
      a_rem   = {5'd0, a_ff} - qk;
      scaled  = {15'd0, sum_ff} << n_ff;
      res     = $signed({1'b0, scaled[46:14]}) - pbpe_pkg::ONE_Q16;
      res_mag = (sat_ff || res > 34'sh0_7FFF_FFFF) ? 31'h7FFF_FFFF : res[30:0];
      h_val   = neg_ff ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
      li      = pbpe_pkg::lerp_index(curve_order, step_ff);
      li1     = li + 2'd1;
      dx      = (pbpe_pkg::QW+1)'(qx_ff[li1]) - (pbpe_pkg::QW+1)'(qx_ff[li]);
      dy      = (pbpe_pkg::QW+1)'(qy_ff[li1]) - (pbpe_pkg::QW+1)'(qy_ff[li]);
      seg1    = job_ff.seg + 7'd1;

      case (state_ff)
         pbpe_pkg::S_IDLE: begin
            if (job_valid) begin
               pop    = 1'b1;
               job_in = job;
               if (job.opcode == pbpe_pkg::OP_WRITE) begin
                  mem_we = (32'(job.entry_index) < 32'(MAX_POINTS));
               end else if (job.invalid) begin
                  rsp_strobe_in = 1'b1;
                  pos_x_in      = '0;
                  pos_y_in      = '0;
                  invalid_in    = 1'b1;
               end else begin
                  mem_re   = 1'b1;
                  state_in = pbpe_pkg::S_READ0;
               end
            end
         end
         pbpe_pkg::S_READ0: begin
            // start anchor and both handles; fetch the next anchor
            ax0_in  = row_ff.anchor_x;
            ay0_in  = row_ff.anchor_y;
            h_in[0] = row_ff.out_handle_x;
            h_in[1] = row_ff.out_handle_y;
            h_in[2] = row_ff.in_handle_x;
            h_in[3] = row_ff.in_handle_y;
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(seg1);
            state_in  = pbpe_pkg::S_READ1;
         end
         pbpe_pkg::S_READ1: begin
            ax1_in   = row_ff.anchor_x;
            ay1_in   = row_ff.anchor_y;
            hsel_in  = 2'd0;
            state_in = direct_handles ? pbpe_pkg::S_BUILD : pbpe_pkg::S_CDIV;
         end
         pbpe_pkg::S_CDIV: begin
            // magnitude and reciprocal multiply for the divide by 15
            neg_in   = h_ff[hsel_ff][31];
            mag_in   = h_ff[hsel_ff][31] ? 32'(-h_ff[hsel_ff]) : h_ff[hsel_ff];
            sat_in   = (mag_in >= pbpe_pkg::SAT_MAG_LIMIT);
            p15_in   = mag_in[24:0] * pbpe_pkg::RECIP15;
            state_in = pbpe_pkg::S_CREM;
         end
         pbpe_pkg::S_CREM: begin
            // x = |v| * 256 / 30 in Q4.24
            x_in     = x_full[27:0];
            state_in = pbpe_pkg::S_CLN;
         end
         pbpe_pkg::S_CLN: begin
            // split x into n * ln2 + r
            n_in     = ln_n;
            r30_in   = {ln_rem[23:0], 6'd0};
            term_in  = pbpe_pkg::ONE_Q30;
            sum_in   = 32'(pbpe_pkg::ONE_Q30);
            k_in     = 4'd1;
            state_in = pbpe_pkg::S_TMUL;
         end
         pbpe_pkg::S_TMUL: begin
            tprod_in = term_ff * r30_ff;
            state_in = pbpe_pkg::S_TDIV;
         end
         pbpe_pkg::S_TDIV: begin
            a_in     = tprod_ff[60:30];
            qe_in    = tprod_ff[60:30] * pbpe_pkg::recip_k(k_ff);
            state_in = pbpe_pkg::S_TFIX;
         end
         pbpe_pkg::S_TFIX: begin
            // correct the quotient estimate and accumulate the term
            term_in = (a_rem >= 36'(k_ff)) ? q_est + 31'd1 : q_est;
            sum_in  = sum_ff + 32'(term_in);
            k_in    = k_ff + 4'd1;
            state_in = (k_ff == pbpe_pkg::TAYLOR_TERMS) ? pbpe_pkg::S_CFIN
                                                        : pbpe_pkg::S_TMUL;
         end
         pbpe_pkg::S_CFIN: begin
            h_in[hsel_ff] = h_val;
            hsel_in       = hsel_ff + 2'd1;
            state_in = (hsel_ff == 2'd3) ? pbpe_pkg::S_BUILD : pbpe_pkg::S_CDIV;
         end
         pbpe_pkg::S_BUILD: begin
            // control points; quadratic drops the end handle
            qx_in[0] = pbpe_pkg::QW'(ax0_ff);
            qx_in[1] = pbpe_pkg::QW'(ax0_ff) + pbpe_pkg::QW'(h_ff[0]);
            qx_in[2] = curve_order ? pbpe_pkg::QW'(ax1_ff) + pbpe_pkg::QW'(h_ff[2])
                                   : pbpe_pkg::QW'(ax1_ff);
            qx_in[3] = pbpe_pkg::QW'(ax1_ff);
            qy_in[0] = pbpe_pkg::QW'(ay0_ff);
            qy_in[1] = pbpe_pkg::QW'(ay0_ff) + pbpe_pkg::QW'(h_ff[1]);
            qy_in[2] = curve_order ? pbpe_pkg::QW'(ay1_ff) + pbpe_pkg::QW'(h_ff[3])
                                   : pbpe_pkg::QW'(ay1_ff);
            qy_in[3] = pbpe_pkg::QW'(ay1_ff);
            step_in  = 3'd0;
            state_in = pbpe_pkg::S_LMUL;
         end
         pbpe_pkg::S_LMUL: begin
            lpx_in   = dx * $signed({1'b0, job_ff.frac});
            lpy_in   = dy * $signed({1'b0, job_ff.frac});
            state_in = pbpe_pkg::S_LADD;
         end
         pbpe_pkg::S_LADD: begin
            // floor of the Q16 product, added in place
            qx_in[li] = qx_ff[li] + pbpe_pkg::QW'(lpx_ff >>> 16);
            qy_in[li] = qy_ff[li] + pbpe_pkg::QW'(lpy_ff >>> 16);
            step_in   = step_ff + 3'd1;
            if (step_ff == ((curve_order ? pbpe_pkg::LERPS_CUBIC
                                         : pbpe_pkg::LERPS_QUAD) - 3'd1)) begin
               state_in = pbpe_pkg::S_DONE;
            end else begin
               state_in = pbpe_pkg::S_LMUL;
            end
         end
         pbpe_pkg::S_DONE: begin
            rsp_strobe_in = 1'b1;
            pos_x_in      = pbpe_pkg::sat32(qx_ff[0]);
            pos_y_in      = pbpe_pkg::sat32(qy_ff[0]);
            invalid_in    = 1'b0;
            state_in      = pbpe_pkg::S_IDLE;
         end
         default: begin
            state_in = pbpe_pkg::S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pbpe_pkg::S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      h_ff   <= h_in;
      ax0_ff <= ax0_in; ay0_ff <= ay0_in; ax1_ff <= ax1_in; ay1_ff <= ay1_in;
      hsel_ff <= hsel_in; mag_ff <= mag_in; neg_ff <= neg_in; sat_ff <= sat_in;
      p15_ff <= p15_in; x_ff <= x_in; n_ff <= n_in; r30_ff <= r30_in;
      term_ff <= term_in; sum_ff <= sum_in; k_ff <= k_in;
      tprod_ff <= tprod_in; a_ff <= a_in; qe_ff <= qe_in;
      qx_ff <= qx_in; qy_ff <= qy_in; step_ff <= step_in;
      lpx_ff <= lpx_in; lpy_ff <= lpy_in;
      pos_x_ff <= pos_x_in; pos_y_ff <= pos_y_in; invalid_ff <= invalid_in;
   end

   // Point table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         row_ff <= mem[mem_raddr];
      end
   end

endmodule

@@ hw/rtl/piecewise_bezier_path_eval.sv @@
// The back end takes a table write, or an evaluate with fewer than two points, every
// cycle while the queue holds one; any other evaluate reads the start and end rows of
// its segment, compresses the four handles unless direct handles are set, runs the
// de Casteljau steps and answers before the back end takes its next job.
// A two-entry queue takes transactions while the back end works; busy = queue full.
// Synchronous active-high reset clears control and config; table is unset.
`include "piecewise_bezier_path_eval_macros.svh"

module piecewise_bezier_path_eval #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [pbpe_pkg::ENTRY_W-1:0]        req_entry_index,
   input  logic signed [pbpe_pkg::COORD_W-1:0] req_anchor_x,
   input  logic signed [pbpe_pkg::COORD_W-1:0] req_anchor_y,
   input  logic signed [pbpe_pkg::COORD_W-1:0] req_out_handle_x,
   input  logic signed [pbpe_pkg::COORD_W-1:0] req_out_handle_y,
   input  logic signed [pbpe_pkg::COORD_W-1:0] req_in_handle_x,
   input  logic signed [pbpe_pkg::COORD_W-1:0] req_in_handle_y,
   input  logic [pbpe_pkg::T_W-1:0]            req_eval_position,
   output logic                                rsp_strobe,
   output logic signed [pbpe_pkg::COORD_W-1:0] rsp_pos_x,
   output logic signed [pbpe_pkg::COORD_W-1:0] rsp_pos_y,
   output logic                                rsp_path_invalid,
   input  logic                                csr_write_enable,
   input  logic [pbpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pbpe_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   logic                       curve_order_ff, curve_order_in;
   logic                       direct_ff, direct_in;
   logic [pbpe_pkg::CNT_W-1:0] count_ff, count_in;

   pbpe_pkg::job_type          front_job, head_job;
   pbpe_pkg::queue_status_type q_status;
   logic                       q_push, q_pop;

   // Terms for the checks
   logic                       inv_rsp, pos_zero, q_has_data;

   // Configuration registers
   always_comb begin
      curve_order_in = curve_order_ff;
      direct_in      = direct_ff;
      count_in       = count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pbpe_pkg::CSR_CURVE_ORDER:    curve_order_in = csr_write_data[0];
            pbpe_pkg::CSR_DIRECT_HANDLES: direct_in      = csr_write_data[0];
            pbpe_pkg::CSR_POINT_COUNT:    count_in       = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_order_ff <= 1'b1;
         direct_ff      <= 1'b0;
         count_ff       <= '0;
      end else begin
         curve_order_ff <= curve_order_in;
         direct_ff      <= direct_in;
         count_ff       <= count_in;
      end
   end

   // Accept a transaction whenever the queue has room
   assign busy   = q_status.full;
   assign q_push = start && !busy;

   pbpe_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .opcode        (req_opcode),
      .entry_index   (req_entry_index),
      .anchor_x      (req_anchor_x),
      .anchor_y      (req_anchor_y),
      .out_handle_x  (req_out_handle_x),
      .out_handle_y  (req_out_handle_y),
      .in_handle_x   (req_in_handle_x),
      .in_handle_y   (req_in_handle_y),
      .eval_position (req_eval_position),
      .point_count   (count_ff),
      .job           (front_job)
   );

   pbpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_job),
      .pop       (q_pop),
      .pop_data  (head_job),
      .status    (q_status)
   );

   pbpe_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .job            (head_job),
      .job_valid      (!q_status.empty),
      .pop            (q_pop),
      .curve_order    (curve_order_ff),
      .direct_handles (direct_ff),
      .rsp_strobe     (rsp_strobe),
      .pos_x          (rsp_pos_x),
      .pos_y          (rsp_pos_y),
      .path_invalid   (rsp_path_invalid)
   );

   // Checks
   assign inv_rsp    = rsp_strobe && rsp_path_invalid;
   assign pos_zero   = (rsp_pos_x == '0) && (rsp_pos_y == '0);
   assign q_has_data = !q_status.empty;

   `PBPE_ASSERT_SAME(a_invalid_zero, clock, reset, inv_rsp, pos_zero, "invalid with position")
   `PBPE_ASSERT_SAME(a_pop_nonempty, clock, reset, q_pop, q_has_data, "pop of empty queue")
   `PBPE_ASSERT_NEXT(a_push_lands, clock, reset, q_push, q_has_data, "push missing from queue")

endmodule
